// ----- sv/pvhc_pkg.sv -----
// Shared constants, types and helpers for the peak/valley half-cycle extractor.
// No dependencies; every other file of the block but pvhc_in_if uses it by scoped names.
package pvhc_pkg;

	localparam int SampleBitsDefault = 16;
	localparam int CountBits         = 16;
	localparam int FifoDepth         = 4;
	localparam int FifoPtrBits       = $clog2(FifoDepth);
	localparam int FifoCountBits     = $clog2(FifoDepth + 1);

	typedef logic [CountBits-1:0] count_t;

	typedef struct packed {
		logic push_a;
		logic push_b;
	} push_t;

	function automatic count_t sat_inc(input count_t value);
		return (value == '1) ? value : value + count_t'(1);
	endfunction

endpackage

// ----- sv/pvhc_in_if.sv -----
// Sample request channel: valid/ready handshake with one sample per request.
// Depends on nothing; width set by SAMPLE_BITS.
interface pvhc_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink (input valid, input sample, input last_sample, output ready);
endinterface

// ----- sv/pvhc_out_if.sv -----
// Segment result channel: valid/ready handshake with one segment per request.
// Depends on pvhc_pkg for the segment number width.
interface pvhc_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic [SAMPLE_BITS-1:0]        seg_range;
	logic signed [SAMPLE_BITS:0]   seg_sum;
	logic [pvhc_pkg::CountBits-1:0] seg_number;
	logic                          final_segment;

	modport source (output valid, output seg_range, output seg_sum, output seg_number,
		output final_segment, input ready);
	modport sink (input valid, input seg_range, input seg_sum, input seg_number,
		input final_segment, output ready);
endinterface

// ----- sv/pvhc_seg.sv -----
// Segment tracker: holds record state and builds up to two segment results per sample.
// Depends on pvhc_pkg.
module pvhc_seg #(
	parameter int SAMPLE_BITS = pvhc_pkg::SampleBitsDefault,
	localparam int EntryBits  = 2 * SAMPLE_BITS + 1 + pvhc_pkg::CountBits + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_sample,
	output pvhc_pkg::push_t               push,
	output logic [EntryBits-1:0]          entry_a,
	output logic [EntryBits-1:0]          entry_b
);

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_FIRST,
		PH_RUN
	} phase_t;

	phase_t                        phase_q, phase_n;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic signed [SAMPLE_BITS-1:0] start_q, start_n;
	logic                          fall_q, fall_n;
	pvhc_pkg::count_t              count_q, count_c1, count_c2;

	logic signed [SAMPLE_BITS:0]   diff;
	logic                          diff_neg, diff_pos, rev;

	logic signed [SAMPLE_BITS:0]   rev_delta, rev_mag, rev_sum;
	logic signed [SAMPLE_BITS:0]   fin_delta, fin_mag, fin_sum;
	logic [EntryBits-1:0]          rev_entry, fin_entry;

	assign diff     = {sample[SAMPLE_BITS-1], sample} - {prev_q[SAMPLE_BITS-1], prev_q};
	assign diff_neg = diff[SAMPLE_BITS];
	assign diff_pos = !diff[SAMPLE_BITS] && (|diff);

	always_comb begin
		start_n = start_q;
		fall_n  = fall_q;
		phase_n = phase_q;
		rev     = 1'b0;
		case (phase_q)
			PH_WAIT: begin
				start_n = sample;
				phase_n = PH_FIRST;
			end
			PH_FIRST: begin
				fall_n  = diff_neg;
				phase_n = PH_RUN;
			end
			default: begin
				if (fall_q ? diff_pos : diff_neg) begin
					rev     = 1'b1;
					start_n = prev_q;
					fall_n  = !fall_q;
				end
			end
		endcase
	end

	assign count_c1 = pvhc_pkg::sat_inc(count_q);
	assign count_c2 = pvhc_pkg::sat_inc(count_c1);

	assign rev_delta = {prev_q[SAMPLE_BITS-1], prev_q} - {start_q[SAMPLE_BITS-1], start_q};
	assign rev_mag   = rev_delta[SAMPLE_BITS] ? -rev_delta : rev_delta;
	assign rev_sum   = {prev_q[SAMPLE_BITS-1], prev_q} + {start_q[SAMPLE_BITS-1], start_q};
	assign rev_entry = {rev_mag[SAMPLE_BITS-1:0], rev_sum, count_c1, 1'b0};

	assign fin_delta = {sample[SAMPLE_BITS-1], sample} - {start_n[SAMPLE_BITS-1], start_n};
	assign fin_mag   = fin_delta[SAMPLE_BITS] ? -fin_delta : fin_delta;
	assign fin_sum   = {sample[SAMPLE_BITS-1], sample} + {start_n[SAMPLE_BITS-1], start_n};
	assign fin_entry = {fin_mag[SAMPLE_BITS-1:0], fin_sum, (rev ? count_c2 : count_c1), 1'b1};

	assign push.push_a = accept && (rev || last_sample);
	assign push.push_b = accept && rev && last_sample;
	assign entry_a     = rev ? rev_entry : fin_entry;
	assign entry_b     = fin_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			prev_q  <= '0;
			start_q <= '0;
			fall_q  <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			if (last_sample) begin
				phase_q <= PH_WAIT;
				prev_q  <= '0;
				start_q <= '0;
				fall_q  <= 1'b0;
				count_q <= '0;
			end else begin
				phase_q <= phase_n;
				prev_q  <= sample;
				start_q <= start_n;
				fall_q  <= fall_n;
				if (rev) begin
					count_q <= count_c1;
				end
			end
		end
	end

endmodule

// ----- sv/pvhc_fifo.sv -----
// Result queue: takes zero, one or two entries per cycle, hands out one per request.
// Depends on pvhc_pkg for depth and the push control group.
module pvhc_fifo #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pvhc_pkg::push_t  push,
	input  logic [WIDTH-1:0] wdata_a,
	input  logic [WIDTH-1:0] wdata_b,
	output logic             space,
	output logic             rvalid,
	input  logic             rready,
	output logic [WIDTH-1:0] rdata
);

	localparam int PB = pvhc_pkg::FifoPtrBits;
	localparam int CB = pvhc_pkg::FifoCountBits;

	logic [WIDTH-1:0] mem_q [pvhc_pkg::FifoDepth];
	logic [PB-1:0]    wptr_q, rptr_q;
	logic [CB-1:0]    count_q;
	logic             pop;
	logic [CB-1:0]    n_push;

	assign rvalid = (count_q != '0);
	assign pop    = rvalid && rready;
	assign space  = (count_q <= CB'(pvhc_pkg::FifoDepth - 2));
	assign rdata  = mem_q[rptr_q];
	assign n_push = CB'(push.push_a) + CB'(push.push_b);

	always_ff @(posedge clk) begin
		if (push.push_a) begin
			mem_q[wptr_q] <= wdata_a;
		end
		if (push.push_b) begin
			mem_q[wptr_q + PB'(1)] <= wdata_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PB'(n_push);
			if (pop) begin
				rptr_q <= rptr_q + PB'(1);
			end
			count_q <= count_q + n_push - CB'(pop);
		end
	end

endmodule

// ----- sv/peak_valley_half_cycle_extractor_core.sv -----
// Peak/valley half-cycle extractor top level: segment tracker plus result queue.
// A segment result is written into the result queue as its closing sample request is accepted.
// Throughput: one sample request per cycle while ready; a closing turn costs two result slots.
// Input ready drops while the four-entry result queue has fewer than two free slots.
// Reset: arst_n clears record state and the queue; the next sample starts a new record.
// Depends on pvhc_pkg, pvhc_in_if, pvhc_out_if, pvhc_seg and pvhc_fifo.
module peak_valley_half_cycle_extractor_core #(
	parameter int SAMPLE_BITS = pvhc_pkg::SampleBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	pvhc_in_if.sink     samples,
	pvhc_out_if.source  segments
);

	localparam int EntryBits = 2 * SAMPLE_BITS + 1 + pvhc_pkg::CountBits + 1;

	pvhc_pkg::push_t      push;
	logic [EntryBits-1:0] entry_a, entry_b, head;
	logic                 space, accept;

	assign samples.ready = space;
	assign accept        = samples.valid && space;

	pvhc_seg #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_seg (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.sample      (samples.sample),
		.last_sample (samples.last_sample),
		.push        (push),
		.entry_a     (entry_a),
		.entry_b     (entry_b)
	);

	pvhc_fifo #(
		.WIDTH (EntryBits)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wdata_a (entry_a),
		.wdata_b (entry_b),
		.space   (space),
		.rvalid  (segments.valid),
		.rready  (segments.ready),
		.rdata   (head)
	);

	assign {segments.seg_range, segments.seg_sum, segments.seg_number,
		segments.final_segment} = head;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for the peak/valley half-cycle extractor core.
// Predicts each segment from the sample stream and checks it against the result channel.
// Depends on pvhc_pkg, pvhc_in_if, pvhc_out_if and peak_valley_half_cycle_extractor_core.
module tb_top;

	localparam int SAMPLE_BITS = pvhc_pkg::SampleBitsDefault;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int REPORT_LIMIT = 100;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [1:0] {
		REC_IDLE,
		REC_FIRST,
		REC_RUNNING
	} rec_phase_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0]      seg_range;
		logic signed [SAMPLE_BITS:0] seg_sum;
		pvhc_pkg::count_t            seg_number;
		logic                        final_segment;
	} segment_t;

	logic clk;
	logic arst_n;

	pvhc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
	pvhc_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

	peak_valley_half_cycle_extractor_core #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(in_ch),
		.segments(out_ch)
	);

	segment_t         seg_expected[$];
	rec_phase_t       rec_phase;
	sample_t          prev_sample;
	sample_t          seg_first;
	logic             going_down;
	pvhc_pkg::count_t seg_count;

	int fail_count = 0;
	int samples_sent = 0;
	int send_gap_max = 7;
	int take_gap_max = 7;
	int result_stall = 0;
	int cycle_count = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void clear_record();
		rec_phase = REC_IDLE;
		prev_sample = '0;
		seg_first = '0;
		going_down = 1'b0;
		seg_count = '0;
	endfunction

	function automatic void push_segment(sample_t a, sample_t b, logic fin);
		logic signed [SAMPLE_BITS:0] delta;
		segment_t seg;
		delta = b - a;
		if (seg_count != '1)
			seg_count++;
		seg.seg_range = (delta < 0) ? SAMPLE_BITS'(-delta) : SAMPLE_BITS'(delta);
		seg.seg_sum = a + b;
		seg.seg_number = seg_count;
		seg.final_segment = fin;
		seg_expected.push_back(seg);
	endfunction

	function automatic void predict_segments(sample_t x, logic is_last);
		case (rec_phase)
			REC_IDLE: begin
				seg_first = x;
				rec_phase = REC_FIRST;
			end
			REC_FIRST: begin
				going_down = x < prev_sample;
				rec_phase = REC_RUNNING;
			end
			default: begin
				if ((going_down && x > prev_sample) || (!going_down && x < prev_sample)) begin
					push_segment(seg_first, prev_sample, 1'b0);
					seg_first = prev_sample;
					going_down = !going_down;
				end
			end
		endcase
		prev_sample = x;
		if (is_last) begin
			push_segment(seg_first, x, 1'b1);
			clear_record();
		end
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			if (fail_count < REPORT_LIMIT)
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		segment_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (seg_expected.size() == 0) begin
				$error("segment result with no request pending: range %0d sum %0d number %0d",
					out_ch.seg_range, out_ch.seg_sum, out_ch.seg_number);
				fail_count++;
			end else begin
				want = seg_expected.pop_front();
				check_field("seg_range", int'(want.seg_range), int'(out_ch.seg_range));
				check_field("seg_sum", int'(want.seg_sum), int'(out_ch.seg_sum));
				check_field("seg_number", int'(want.seg_number), int'(out_ch.seg_number));
				check_field("final_segment", int'(want.final_segment),
					int'(out_ch.final_segment));
			end
		end
	end

	initial begin : result_taker
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, take_gap_max);
			repeat (gap) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
			end
			@(negedge clk);
			while (result_stall > 0) begin
				out_ch.ready <= 1'b0;
				result_stall--;
				@(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	task automatic send_sample(input sample_t x, input logic is_last);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.sample <= x;
		in_ch.last_sample <= is_last;
		do @(posedge clk); while (!in_ch.ready);
		predict_segments(x, is_last);
		samples_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (seg_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_record(input int len);
		int level;
		int step_max;
		logic wide;
		wide = ($urandom_range(0, 3) == 0);
		step_max = $urandom_range(0, 4);
		level = int'($signed(16'($urandom)));
		for (int i = 0; i < len; i++) begin
			if (wide)
				level = int'($signed(16'($urandom)));
			else
				level += $urandom_range(0, 2 * step_max) - step_max;
			if (level > 32767)
				level = 32767;
			if (level < -32768)
				level = -32768;
			send_sample(sample_t'(level), i == len - 1);
		end
	endtask

	task automatic test_single_sample_records();
		send_sample(16'sh7fff, 1'b1);
		send_sample(-16'sh8000, 1'b1);
		send_sample(16'sh0000, 1'b1);
		wait_drained();
	endtask

	task automatic test_flat_runs();
		send_sample(16'sd5, 1'b0);
		send_sample(16'sd5, 1'b0);
		send_sample(16'sd5, 1'b0);
		send_sample(16'sd5, 1'b1);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(-16'sd3, 1'b0);
		send_sample(-16'sd3, 1'b0);
		send_sample(16'sd4, 1'b1);
		wait_drained();
	endtask

	task automatic test_full_scale_swings();
		send_sample(-16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(-16'sh8000, 1'b1);
		send_sample(16'sh7fff, 1'b0);
		send_sample(-16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sd100, 1'b0);
		send_sample(-16'sd100, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_records(input int target);
		int start;
		start = samples_sent;
		while (samples_sent - start < target) begin
			if ($urandom_range(0, 7) == 0)
				send_random_record(1);
			else
				send_random_record($urandom_range(2, 24));
		end
		wait_drained();
	endtask

	task automatic test_result_backpressure();
		send_gap_max = 0;
		result_stall = 200;
		for (int i = 0; i < 40; i++)
			send_sample((i % 2 == 0) ? sample_t'($urandom_range(0, 32767))
				: sample_t'(-int'($urandom_range(1, 32768))), i == 39);
		wait_drained();
		send_gap_max = 7;
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		in_ch.last_sample = 1'b0;
		clear_record();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_single_sample_records();
		test_flat_runs();
		test_full_scale_swings();
		test_random_records(1200);
		test_result_backpressure();
		send_gap_max = 0;
		take_gap_max = 0;
		test_random_records(200);
		send_gap_max = 7;
		take_gap_max = 7;
		test_random_records(200);

		wait_drained();
		repeat (8) @(posedge clk);
		if (seg_expected.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
